### rtl/mcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types, constants and the direction order table of the maze carver.
// ----------------------------------------------------------------------------
package mcb_pkg;

   // field widths of the channels
   localparam int COORD_W   = 5;
   localparam int ORDER_W   = 5;
   localparam int EVENT_W   = 3;
   localparam int DIR_W     = 2;
   localparam int DIM_W     = 6;
   localparam int CSR_IDX_W = 4;

   // grid limits and clamped dimension width (holds up to 127)
   localparam int MAX_COLS_DEF = 32;
   localparam int MAX_ROWS_DEF = 32;
   localparam int LIM_W        = 7;
   localparam int MIN_DIM      = 2;

   // visited map generation tag width
   localparam int EPOCH_W = 8;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_USED = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_USED = 4'd1;
   localparam logic [DIM_W-1:0]     COLS_RESET    = 6'd25;
   localparam logic [DIM_W-1:0]     ROWS_RESET    = 6'd18;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_STARTED     = 3'd0,
      EV_CARVED      = 3'd1,
      EV_BACKTRACKED = 3'd2,
      EV_FINISHED    = 3'd3,
      EV_IGNORED     = 3'd4
   } event_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_DOWN  = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_START,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STK_NONE,
      STK_INIT,
      STK_PUSH,
      STK_POP
   } stk_op_type;

   typedef struct packed {
      stk_op_type op;
      logic       rd_en;
   } stk_cmd_type;

   typedef struct packed {
      logic clear;
      logic new_epoch;
      logic rd_en;
      logic mark;
   } vis_cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
      logic wrap;
   } vis_stat_type;

   // lexicographic permutations of 0..3, first trial in the top two bits
   localparam int PERM_COUNT = 24;
   localparam logic [7:0] PERM_TABLE [PERM_COUNT] = '{
      8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39,
      8'h4B, 8'h4E, 8'h63, 8'h6C, 8'h72, 8'h78,
      8'h87, 8'h8D, 8'h93, 8'h9C, 8'hB1, 8'hB4,
      8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4
   };
   localparam logic [7:0] PERM_IDENTITY = 8'h1B;

   function automatic dir_type perm_dir(input logic [ORDER_W-1:0] ord,
                                        input logic [1:0] pos);
      logic [7:0] row;
      logic [2:0] sel;
      if (ord < ORDER_W'(PERM_COUNT)) begin
         row = PERM_TABLE[ord];
      end else begin
         row = PERM_IDENTITY;
      end
      sel = {~pos, 1'b0};
      return dir_type'(row[sel +: 2]);
   endfunction

endpackage
`default_nettype wire

### rtl/mcb_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_channels
// Valid/ready channels of the maze carver: command, result and register write.
// ----------------------------------------------------------------------------
interface mcb_req_if;
   logic                               valid;
   logic                               ready;
   logic                               command;
   logic [mcb_pkg::COORD_W-1:0]        start_x;
   logic [mcb_pkg::COORD_W-1:0]        start_y;
   logic [mcb_pkg::ORDER_W-1:0]        dir_order;

   modport source(output valid, command, start_x, start_y, dir_order, input ready);
   modport sink(input valid, command, start_x, start_y, dir_order, output ready);
endinterface

interface mcb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mcb_pkg::EVENT_W-1:0]        event_res;
   logic [mcb_pkg::COORD_W-1:0]        from_x;
   logic [mcb_pkg::COORD_W-1:0]        from_y;
   logic [mcb_pkg::DIR_W-1:0]          carve_dir;
   logic [mcb_pkg::COORD_W-1:0]        to_x;
   logic [mcb_pkg::COORD_W-1:0]        to_y;

   modport source(output valid, event_res, from_x, from_y, carve_dir, to_x, to_y,
                  input ready);
   modport sink(input valid, event_res, from_x, from_y, carve_dir, to_x, to_y,
                output ready);
endinterface

interface mcb_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mcb_pkg::CSR_IDX_W-1:0]      index;
   logic [mcb_pkg::DIM_W-1:0]          wdata;

   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface
`default_nettype wire

### rtl/maze_carve_backtracker_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// maze_carve_backtracker_core
// Randomized depth-first maze carver with stack and visited map in memory.
// ----------------------------------------------------------------------------
// One result per command. A start goes through the start state to the result
// register; a step goes through one probe state per direction tried, and each
// in-grid direction also costs one visited-map read and its check, up to all
// four directions. Results wait in an output register, so a new command is taken
// as soon as the sequencer is idle. After reset the visited map is swept over
// all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) entries (1024 by default) before the
// first command is taken; the same sweep runs ahead of the 256th started maze
// and every 255th one after it. Register writes are taken at any time.
// ----------------------------------------------------------------------------
module maze_carve_backtracker_core #(
   parameter int MAX_COLS = mcb_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = mcb_pkg::MAX_ROWS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   mcb_req_if.sink    req_ch,
   mcb_rsp_if.source  rsp_ch,
   mcb_csr_if.sink    csr_ch
);

   localparam int XW    = $clog2(MAX_COLS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int AW    = XW + YW;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int LW    = mcb_pkg::LIM_W;
   localparam int OW    = mcb_pkg::COORD_W;

   mcb_pkg::state_type    state_ff, state_in;
   mcb_pkg::vis_cmd_type  vis_cmd;
   mcb_pkg::vis_stat_type vis_stat;
   mcb_pkg::stk_cmd_type  stk_cmd;
   logic [AW-1:0]         vis_addr;
   logic [AW-1:0]         stk_cell;
   logic [AW-1:0]         stk_top;
   logic [CW-1:0]         stk_count;

   // configuration
   logic [mcb_pkg::DIM_W-1:0] cols_used_ff;
   logic [mcb_pkg::DIM_W-1:0] rows_used_ff;
   logic [LW-1:0]             cols_lim;
   logic [LW-1:0]             rows_lim;

   // control
   logic running_ff;
   logic pending_ff;
   logic rsp_valid_ff;

   // item payload
   logic [XW-1:0]                 sx_ff;
   logic [YW-1:0]                 sy_ff;
   logic [mcb_pkg::ORDER_W-1:0]   ord_ff;
   logic [1:0]                    idx_ff;
   logic [XW-1:0]                 nx_ff;
   logic [YW-1:0]                 ny_ff;
   mcb_pkg::dir_type              dir_ff;

   mcb_pkg::event_type            res_ev_ff;
   logic [OW-1:0]                 res_fx_ff, res_fy_ff, res_tx_ff, res_ty_ff;
   logic [mcb_pkg::DIR_W-1:0]     res_dir_ff;

   mcb_pkg::event_type            rsp_ev_ff;
   logic [OW-1:0]                 rsp_fx_ff, rsp_fy_ff, rsp_tx_ff, rsp_ty_ff;
   logic [mcb_pkg::DIR_W-1:0]     rsp_dir_ff;

   // decode
   logic             req_acc;
   logic             out_free;
   logic             start_ok;
   logic             step_ok;
   logic [XW-1:0]    cur_x;
   logic [YW-1:0]    cur_y;
   mcb_pkg::dir_type probe_dir;
   logic             probe_ok;
   logic [XW-1:0]    probe_nx;
   logic [YW-1:0]    probe_ny;
   logic             last_try;
   logic             carve_ok;
   logic             pop_now;
   logic             is_start;

   mcb_visit_map #(
      .ADDR_W (AW)
   ) u_visit (
      .clock (clock),
      .reset (reset),
      .cmd   (vis_cmd),
      .addr  (vis_addr),
      .stat  (vis_stat)
   );

   mcb_path_stack #(
      .ADDR_W (AW),
      .DEPTH  (CELLS),
      .CNT_W  (CW)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stk_cmd),
      .push_cell (stk_cell),
      .top_cell  (stk_top),
      .count     (stk_count)
   );

   // saturate grid size into 2..MAX
   always_comb begin
      if (cols_used_ff < mcb_pkg::DIM_W'(mcb_pkg::MIN_DIM)) begin
         cols_lim = LW'(mcb_pkg::MIN_DIM);
      end else if (LW'(cols_used_ff) > LW'(MAX_COLS)) begin
         cols_lim = LW'(MAX_COLS);
      end else begin
         cols_lim = LW'(cols_used_ff);
      end
      if (rows_used_ff < mcb_pkg::DIM_W'(mcb_pkg::MIN_DIM)) begin
         rows_lim = LW'(mcb_pkg::MIN_DIM);
      end else if (LW'(rows_used_ff) > LW'(MAX_ROWS)) begin
         rows_lim = LW'(MAX_ROWS);
      end else begin
         rows_lim = LW'(rows_used_ff);
      end
   end

   assign req_ch.ready = (state_ff == mcb_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign is_start     = (mcb_pkg::cmd_type'(req_ch.command) == mcb_pkg::CMD_START);

   assign start_ok = (LW'(req_ch.start_x) < cols_lim) && (LW'(req_ch.start_y) < rows_lim);
   assign step_ok  = running_ff && (stk_count != '0);

   assign cur_x     = stk_top[XW-1:0];
   assign cur_y     = stk_top[AW-1:XW];
   assign probe_dir = mcb_pkg::perm_dir(ord_ff, idx_ff);
   assign last_try  = (idx_ff == 2'd3);

   // neighbor of the top cell in the direction under trial; both of its
   // coordinates must lie inside the current grid
   always_comb begin
      probe_ok = 1'b0;
      probe_nx = cur_x;
      probe_ny = cur_y;
      unique case (probe_dir)
         mcb_pkg::DIR_UP: begin
            probe_ny = cur_y - YW'(1);
            probe_ok = (cur_y != '0) && (LW'(probe_ny) < rows_lim) &&
                       (LW'(cur_x) < cols_lim);
         end
         mcb_pkg::DIR_RIGHT: begin
            probe_nx = cur_x + XW'(1);
            probe_ok = ((LW'(cur_x) + LW'(1)) < cols_lim) && (LW'(cur_y) < rows_lim);
         end
         mcb_pkg::DIR_DOWN: begin
            probe_ny = cur_y + YW'(1);
            probe_ok = ((LW'(cur_y) + LW'(1)) < rows_lim) && (LW'(cur_x) < cols_lim);
         end
         mcb_pkg::DIR_LEFT: begin
            probe_nx = cur_x - XW'(1);
            probe_ok = (cur_x != '0) && (LW'(probe_nx) < cols_lim) &&
                       (LW'(cur_y) < rows_lim);
         end
      endcase
   end

   assign carve_ok = !vis_stat.hit && (stk_count < CW'(CELLS));
   assign pop_now  = ((state_ff == mcb_pkg::ST_PROBE) && !probe_ok && last_try) ||
                     ((state_ff == mcb_pkg::ST_CHECK) && !carve_ok && last_try);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcb_pkg::ST_WIPE: begin
            if (!vis_stat.busy) begin
               state_in = pending_ff ? mcb_pkg::ST_START : mcb_pkg::ST_IDLE;
            end
         end
         mcb_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (is_start) begin
                  if (!start_ok) begin
                     state_in = mcb_pkg::ST_DONE;
                  end else if (vis_stat.wrap) begin
                     state_in = mcb_pkg::ST_WIPE;
                  end else begin
                     state_in = mcb_pkg::ST_START;
                  end
               end else begin
                  state_in = step_ok ? mcb_pkg::ST_PROBE : mcb_pkg::ST_DONE;
               end
            end
         end
         mcb_pkg::ST_START: state_in = mcb_pkg::ST_DONE;
         mcb_pkg::ST_PROBE: begin
            if (probe_ok) begin
               state_in = mcb_pkg::ST_CHECK;
            end else if (last_try) begin
               state_in = mcb_pkg::ST_DONE;
            end
         end
         mcb_pkg::ST_CHECK: begin
            if (carve_ok || last_try) begin
               state_in = mcb_pkg::ST_DONE;
            end else begin
               state_in = mcb_pkg::ST_PROBE;
            end
         end
         mcb_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mcb_pkg::ST_IDLE;
            end
         end
         default: state_in = mcb_pkg::ST_IDLE;
      endcase
   end

   // memory commands
   always_comb begin
      vis_cmd  = '0;
      stk_cmd  = '{op: mcb_pkg::STK_NONE, rd_en: 1'b0};
      vis_addr = {probe_ny, probe_nx};
      stk_cell = {ny_ff, nx_ff};
      unique case (state_ff)
         mcb_pkg::ST_IDLE: begin
            if (req_acc) begin
               vis_cmd.clear = is_start && start_ok && vis_stat.wrap;
               stk_cmd.rd_en = !is_start && step_ok;
            end
         end
         mcb_pkg::ST_START: begin
            vis_cmd.new_epoch = 1'b1;
            vis_cmd.mark      = 1'b1;
            vis_addr          = {sy_ff, sx_ff};
            stk_cmd.op        = mcb_pkg::STK_INIT;
            stk_cell          = {sy_ff, sx_ff};
         end
         mcb_pkg::ST_PROBE: begin
            vis_cmd.rd_en = probe_ok;
            if (pop_now) begin
               stk_cmd.op = mcb_pkg::STK_POP;
            end
         end
         mcb_pkg::ST_CHECK: begin
            vis_addr = {ny_ff, nx_ff};
            if (carve_ok) begin
               vis_cmd.mark = 1'b1;
               stk_cmd.op   = mcb_pkg::STK_PUSH;
            end else if (pop_now) begin
               stk_cmd.op = mcb_pkg::STK_POP;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcb_pkg::ST_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_used_ff <= mcb_pkg::COLS_RESET;
         rows_used_ff <= mcb_pkg::ROWS_RESET;
         running_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == mcb_pkg::CSR_COLS_USED) begin
               cols_used_ff <= csr_ch.wdata;
            end else if (csr_ch.index == mcb_pkg::CSR_ROWS_USED) begin
               rows_used_ff <= csr_ch.wdata;
            end
         end
         if (vis_cmd.clear) begin
            pending_ff <= 1'b1;
         end else if (state_ff == mcb_pkg::ST_WIPE && !vis_stat.busy) begin
            pending_ff <= 1'b0;
         end
         if (state_ff == mcb_pkg::ST_START) begin
            running_ff <= 1'b1;
         end else if (pop_now && stk_count == CW'(1)) begin
            running_ff <= 1'b0;
         end
         if (state_ff == mcb_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         sx_ff  <= XW'(req_ch.start_x);
         sy_ff  <= YW'(req_ch.start_y);
         ord_ff <= req_ch.dir_order;
         idx_ff <= 2'd0;
         res_ev_ff  <= mcb_pkg::EV_IGNORED;
         res_fx_ff  <= '0;
         res_fy_ff  <= '0;
         res_dir_ff <= '0;
         res_tx_ff  <= '0;
         res_ty_ff  <= '0;
      end
      if (state_ff == mcb_pkg::ST_START) begin
         res_ev_ff <= mcb_pkg::EV_STARTED;
         res_fx_ff <= OW'(sx_ff);
         res_fy_ff <= OW'(sy_ff);
      end
      if (state_ff == mcb_pkg::ST_PROBE && probe_ok) begin
         nx_ff  <= probe_nx;
         ny_ff  <= probe_ny;
         dir_ff <= probe_dir;
      end
      // advance to the next direction when this one is blocked
      if ((state_ff == mcb_pkg::ST_PROBE && !probe_ok && !last_try) ||
          (state_ff == mcb_pkg::ST_CHECK && !carve_ok && !last_try)) begin
         idx_ff <= idx_ff + 2'd1;
      end
      if (state_ff == mcb_pkg::ST_CHECK && carve_ok) begin
         res_ev_ff  <= mcb_pkg::EV_CARVED;
         res_fx_ff  <= OW'(cur_x);
         res_fy_ff  <= OW'(cur_y);
         res_dir_ff <= dir_ff;
         res_tx_ff  <= OW'(nx_ff);
         res_ty_ff  <= OW'(ny_ff);
      end
      if (pop_now) begin
         res_ev_ff <= (stk_count == CW'(1)) ? mcb_pkg::EV_FINISHED
                                            : mcb_pkg::EV_BACKTRACKED;
         res_fx_ff <= OW'(cur_x);
         res_fy_ff <= OW'(cur_y);
      end
      if (state_ff == mcb_pkg::ST_DONE && out_free) begin
         rsp_ev_ff  <= res_ev_ff;
         rsp_fx_ff  <= res_fx_ff;
         rsp_fy_ff  <= res_fy_ff;
         rsp_dir_ff <= res_dir_ff;
         rsp_tx_ff  <= res_tx_ff;
         rsp_ty_ff  <= res_ty_ff;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.event_res = rsp_ev_ff;
   assign rsp_ch.from_x    = rsp_fx_ff;
   assign rsp_ch.from_y    = rsp_fy_ff;
   assign rsp_ch.carve_dir = rsp_dir_ff;
   assign rsp_ch.to_x      = rsp_tx_ff;
   assign rsp_ch.to_y      = rsp_ty_ff;

`ifndef NO_ASSERTIONS
   a_wipe_blocks_cmds: assert property (@(posedge clock) disable iff (reset)
      vis_stat.busy |-> (state_ff == mcb_pkg::ST_WIPE))
      else $error("visited map sweep outside wipe state");

   a_running_has_path: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (stk_count != '0))
      else $error("running with an empty path stack");

   a_carve_pushes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcb_pkg::ST_CHECK && carve_ok) |=>
         (stk_count == CW'($past(stk_count) + CW'(1))))
      else $error("carve did not grow the path stack");

   a_probe_when_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcb_pkg::ST_PROBE) |-> running_ff)
      else $error("probing a direction while no maze is running");
`endif

endmodule
`default_nettype wire

### rtl/mcb_visit_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_visit_map
// Visited map held as generation tags in one synchronous memory. A cell is
// visited when its tag equals the current generation; a sweep zeroes all tags
// after reset and whenever the generation counter runs out.
// ----------------------------------------------------------------------------
module mcb_visit_map #(
   parameter int ADDR_W = 10
) (
   input  wire                          clock,
   input  wire                          reset,
   input  mcb_pkg::vis_cmd_type         cmd,
   input  wire  [ADDR_W-1:0]            addr,
   output mcb_pkg::vis_stat_type        stat
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [mcb_pkg::EPOCH_W-1:0] tag_mem [DEPTH];
   logic [mcb_pkg::EPOCH_W-1:0] rd_tag_ff;
   logic [mcb_pkg::EPOCH_W-1:0] epoch_ff;
   logic [ADDR_W-1:0]           wipe_addr_ff;
   logic                        busy_ff;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [mcb_pkg::EPOCH_W-1:0] wr_tag;

   always_comb begin
      wr_en   = busy_ff | cmd.mark;
      wr_addr = busy_ff ? wipe_addr_ff : addr;
      if (busy_ff) begin
         wr_tag = '0;
      end else if (cmd.new_epoch) begin
         wr_tag = epoch_ff + mcb_pkg::EPOCH_W'(1);
      end else begin
         wr_tag = epoch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (cmd.rd_en) begin
         rd_tag_ff <= tag_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         wipe_addr_ff <= '0;
         epoch_ff     <= '0;
      end else if (busy_ff) begin
         wipe_addr_ff <= wipe_addr_ff + ADDR_W'(1);
         if (wipe_addr_ff == '1) begin
            busy_ff  <= 1'b0;
            epoch_ff <= '0;
         end
      end else if (cmd.clear) begin
         busy_ff      <= 1'b1;
         wipe_addr_ff <= '0;
      end else if (cmd.new_epoch) begin
         epoch_ff <= epoch_ff + mcb_pkg::EPOCH_W'(1);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.hit  = (rd_tag_ff == epoch_ff);
   assign stat.wrap = (epoch_ff == '1);

endmodule
`default_nettype wire

### rtl/mcb_path_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcb_path_stack
// Path stack of cell addresses in one synchronous memory, with its fill count.
// The top entry is read into a register on a read request, valid in the next cycle.
// ----------------------------------------------------------------------------
module mcb_path_stack #(
   parameter int ADDR_W = 10,
   parameter int DEPTH  = 1024,
   parameter int CNT_W  = 11
) (
   input  wire                        clock,
   input  wire                        reset,
   input  mcb_pkg::stk_cmd_type       cmd,
   input  wire  [ADDR_W-1:0]          push_cell,
   output logic [ADDR_W-1:0]          top_cell,
   output logic [CNT_W-1:0]           count
);

   localparam int IDX_W = $clog2(DEPTH);

   logic [ADDR_W-1:0] stk_mem [DEPTH];
   logic [ADDR_W-1:0] top_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  top_idx;

   assign top_idx = count_ff - CNT_W'(1);

   always_comb begin
      unique case (cmd.op)
         mcb_pkg::STK_INIT: count_in = CNT_W'(1);
         mcb_pkg::STK_PUSH: count_in = count_ff + CNT_W'(1);
         mcb_pkg::STK_POP:  count_in = count_ff - CNT_W'(1);
         default:           count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == mcb_pkg::STK_INIT) begin
         stk_mem[0] <= push_cell;
      end else if (cmd.op == mcb_pkg::STK_PUSH) begin
         stk_mem[count_ff[IDX_W-1:0]] <= push_cell;
      end
      if (cmd.rd_en) begin
         top_ff <= stk_mem[top_idx[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_cell = top_ff;
   assign count    = count_ff;

endmodule
`default_nettype wire

### tb/sv/mcb_carve_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcb_carve_checker
// Watches the command, result and register channels of the maze carver. It
// keeps its own grid size, visited map and path stack, predicts the event of
// every accepted command and compares each returned result field by field.
// ----------------------------------------------------------------------------
module mcb_carve_checker (
   input  wire  clock,
   input  wire  reset,
   mcb_req_if   req_ch,
   mcb_rsp_if   rsp_ch,
   mcb_csr_if   csr_ch,
   output int   mismatch_count,
   output int   outstanding
);
   import mcb_pkg::*;

   localparam int GRID_COLS   = MAX_COLS_DEF;
   localparam int GRID_ROWS   = MAX_ROWS_DEF;
   localparam int CELL_COUNT  = GRID_COLS * GRID_ROWS;

   typedef struct packed {
      event_type            ev;
      logic [COORD_W-1:0]   from_x;
      logic [COORD_W-1:0]   from_y;
      dir_type              dir;
      logic [COORD_W-1:0]   to_x;
      logic [COORD_W-1:0]   to_y;
   } maze_event_type;

   logic [DIM_W-1:0] cols_reg;
   logic [DIM_W-1:0] rows_reg;
   bit               visited [CELL_COUNT];
   int               trail [CELL_COUNT];
   int               trail_depth;
   bit               maze_active;
   maze_event_type   pending_events [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic int used_dim(input logic [DIM_W-1:0] raw, input int limit);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   // Decode the order index as a factorial-base number; out-of-range indexes
   // fall back to the identity order.
   function automatic dir_type trial_dir(input logic [ORDER_W-1:0] ord, input int pos);
      int      pool [4];
      int      rank;
      int      radix;
      int      pick;
      dir_type chosen;
      pool   = '{0, 1, 2, 3};
      rank   = (ord < 24) ? int'(ord) : 0;
      radix  = 6;
      chosen = DIR_UP;
      for (int i = 0; i <= pos; i++) begin
         pick   = rank / radix;
         rank   = rank % radix;
         chosen = dir_type'(2'(pool[pick]));
         for (int j = pick; j < 3; j++) pool[j] = pool[j + 1];
         if (i < 3) radix = radix / (3 - i);
      end
      return chosen;
   endfunction

   function automatic maze_event_type carve_event(input cmd_type cmd,
                                                  input logic [COORD_W-1:0] sx,
                                                  input logic [COORD_W-1:0] sy,
                                                  input logic [ORDER_W-1:0] ord);
      maze_event_type res;
      int             cols;
      int             rows;
      int             top;
      int             x;
      int             y;
      int             nx;
      int             ny;
      int             cell_idx;
      dir_type        d;
      res    = '0;
      res.ev = EV_IGNORED;
      cols   = used_dim(cols_reg, GRID_COLS);
      rows   = used_dim(rows_reg, GRID_ROWS);

      if (cmd == CMD_START) begin
         if (sx >= cols || sy >= rows) return res;
         foreach (visited[i]) visited[i] = 1'b0;
         cell_idx          = int'(sy) * GRID_COLS + int'(sx);
         visited[cell_idx] = 1'b1;
         trail[0]          = cell_idx;
         trail_depth       = 1;
         maze_active       = 1'b1;
         res.ev            = EV_STARTED;
         res.from_x        = sx;
         res.from_y        = sy;
         return res;
      end

      if (!maze_active || trail_depth == 0) return res;

      top        = trail[trail_depth - 1];
      x          = top % GRID_COLS;
      y          = top / GRID_COLS;
      res.from_x = COORD_W'(x);
      res.from_y = COORD_W'(y);
      for (int i = 0; i < 4; i++) begin
         d  = trial_dir(ord, i);
         nx = x + int'(d == DIR_RIGHT) - int'(d == DIR_LEFT);
         ny = y + int'(d == DIR_DOWN) - int'(d == DIR_UP);
         if (nx >= 0 && nx < cols && ny >= 0 && ny < rows) begin
            cell_idx = ny * GRID_COLS + nx;
            if (!visited[cell_idx] && trail_depth < CELL_COUNT) begin
               visited[cell_idx]  = 1'b1;
               trail[trail_depth] = cell_idx;
               trail_depth++;
               res.ev   = EV_CARVED;
               res.dir  = d;
               res.to_x = COORD_W'(nx);
               res.to_y = COORD_W'(ny);
               return res;
            end
         end
      end

      // dead end: drop the top cell
      trail_depth--;
      if (trail_depth == 0) begin
         maze_active = 1'b0;
         res.ev      = EV_FINISHED;
      end else begin
         res.ev = EV_BACKTRACKED;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      maze_event_type want;
      if (reset) begin
         cols_reg    = COLS_RESET;
         rows_reg    = ROWS_RESET;
         trail_depth = 0;
         maze_active = 1'b0;
         foreach (visited[i]) visited[i] = 1'b0;
         pending_events.delete();
      end else begin
         // results first, so a transfer never matches a command taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_events.size() == 0) begin
               report_mismatch("result with no command outstanding, event",
                               int'(rsp_ch.event_res), -1);
            end else begin
               want = pending_events.pop_front();
               if (rsp_ch.event_res !== want.ev)
                  report_mismatch("event_res", int'(rsp_ch.event_res), int'(want.ev));
               if (rsp_ch.from_x !== want.from_x)
                  report_mismatch("from_x", int'(rsp_ch.from_x), int'(want.from_x));
               if (rsp_ch.from_y !== want.from_y)
                  report_mismatch("from_y", int'(rsp_ch.from_y), int'(want.from_y));
               if (rsp_ch.carve_dir !== want.dir)
                  report_mismatch("carve_dir", int'(rsp_ch.carve_dir), int'(want.dir));
               if (rsp_ch.to_x !== want.to_x)
                  report_mismatch("to_x", int'(rsp_ch.to_x), int'(want.to_x));
               if (rsp_ch.to_y !== want.to_y)
                  report_mismatch("to_y", int'(rsp_ch.to_y), int'(want.to_y));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_COLS_USED: begin
                  cols_reg = csr_ch.wdata;
               end
               CSR_ROWS_USED: begin
                  rows_reg = csr_ch.wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_events = {pending_events,
                              carve_event(cmd_type'(req_ch.command), req_ch.start_x,
                                          req_ch.start_y, req_ch.dir_order)};
         end
      end
      outstanding = pending_events.size();
   end

endmodule

### tb/sv/tb_maze_carve_backtracker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_maze_carve_backtracker_core
// Drives start and step commands into the maze carver: a directed pass over
// grid corners, idle steps, starts outside the grid and order indexes past the
// table, then random mazes on mostly small grids, some left open across a grid
// change. Sender gaps and receiver stalls vary by phase; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_maze_carve_backtracker_core;
   import mcb_pkg::*;

   localparam int RUN_ITEMS       = 1500;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int STEP_CAP        = 160;
   localparam int SPARE_IDX_FIRST = 2;
   localparam int SPARE_IDX_LAST  = 15;
   localparam int DRAIN_CYCLES    = 16;

   logic clock = 1'b0;
   logic reset;
   int   send_gap_pct   = 0;
   int   recv_stall_pct = 0;
   int   cycle_count    = 0;
   int   items_sent     = 0;
   int   grid_cols;
   int   grid_rows;
   int   mismatches;
   int   outstanding;

   mcb_req_if req_ch ();
   mcb_rsp_if rsp_ch ();
   mcb_csr_if csr_ch ();

   maze_carve_backtracker_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   mcb_carve_checker carve_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int used_dim(input int raw, input int limit);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic int random_order();
      if ($urandom_range(99) < 90) return $urandom_range(0, 23);
      return $urandom_range(24, 31);
   endfunction

   task automatic send_command(input cmd_type cmd, input int sx, input int sy, input int ord);
      if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.start_x   <= COORD_W'(sx);
      req_ch.start_y   <= COORD_W'(sy);
      req_ch.dir_order <= ORDER_W'(ord);
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_grid(input int cols_raw, input int rows_raw, input bit spare);
      write_reg(CSR_COLS_USED, DIM_W'(cols_raw));
      write_reg(CSR_ROWS_USED, DIM_W'(rows_raw));
      if (spare) begin
         write_reg(CSR_IDX_W'($urandom_range(SPARE_IDX_FIRST, SPARE_IDX_LAST)),
                   DIM_W'($urandom_range(0, 63)));
      end
      csr_ch.valid <= 1'b0;
      grid_cols = used_dim(cols_raw, MAX_COLS_DEF);
      grid_rows = used_dim(rows_raw, MAX_ROWS_DEF);
   endtask

   initial begin : stimulus
      int  sel;
      int  cols_raw;
      int  rows_raw;
      int  steps;
      int  phase;
      bit  maze_open;
      bit  keep;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_START;
      req_ch.start_x   <= '0;
      req_ch.start_y   <= '0;
      req_ch.dir_order <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= CSR_COLS_USED;
      csr_ch.wdata     <= '0;
      grid_cols = int'(COLS_RESET);
      grid_rows = int'(ROWS_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset grid is 25 by 18: idle step, starts just outside, far corner
      send_command(CMD_STEP, 31, 31, 31);
      send_command(CMD_START, 25, 0, 0);
      send_command(CMD_START, 0, 18, 0);
      send_command(CMD_START, 31, 31, 23);
      send_command(CMD_START, 24, 17, 0);
      send_command(CMD_STEP, 0, 0, 0);
      send_command(CMD_STEP, 0, 0, 23);
      send_command(CMD_STEP, 0, 0, 24);
      send_command(CMD_STEP, 0, 0, 31);
      drain();

      // saturated sizes: 63 columns holds at the maximum, 0 rows at the minimum
      set_grid(63, 0, 1'b1);
      send_command(CMD_START, 31, 1, 0);
      send_command(CMD_STEP, 5, 9, 12);
      send_command(CMD_STEP, 0, 0, 18);
      send_command(CMD_STEP, 0, 0, 7);
      send_command(CMD_STEP, 0, 0, 31);
      send_command(CMD_STEP, 0, 0, 0);
      drain();

      // restart on a two-column grid while the previous maze still runs
      set_grid(1, 33, 1'b0);
      send_command(CMD_START, 1, 31, 0);
      send_command(CMD_STEP, 0, 0, 5);
      send_command(CMD_STEP, 0, 0, 23);
      send_command(CMD_STEP, 0, 0, 1);

      phase     = 0;
      maze_open = 1'b1;
      while (items_sent < RUN_ITEMS) begin
         drain();
         case (phase % 4)
            0: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_gap_pct   = 65;
               recv_stall_pct = 0;
            end
            2: begin
               send_gap_pct   = 0;
               recv_stall_pct = 65;
            end
            default: begin
               send_gap_pct   = 33;
               recv_stall_pct = 33;
            end
         endcase

         sel = $urandom_range(99);
         if (sel < 70) begin
            cols_raw = $urandom_range(2, 6);
            rows_raw = $urandom_range(2, 6);
         end else if (sel < 85) begin
            cols_raw = $urandom_range(2, 12);
            rows_raw = $urandom_range(2, 12);
         end else if (sel < 93) begin
            cols_raw = $urandom_range(0, 63);
            rows_raw = $urandom_range(0, 63);
         end else begin
            cols_raw = $urandom_range(32, 63);
            rows_raw = $urandom_range(32, 63);
         end
         set_grid(cols_raw, rows_raw, $urandom_range(9) == 0);

         // an open maze may carry on under the new grid size
         keep = maze_open && ($urandom_range(99) < 70);
         if (keep) begin
            steps = $urandom_range(1, 2 * grid_cols * grid_rows);
         end else begin
            if ($urandom_range(99) < 10) begin
               send_command(CMD_START, $urandom_range(0, 31), $urandom_range(0, 31),
                            random_order());
            end else begin
               send_command(CMD_START, $urandom_range(0, grid_cols - 1),
                            $urandom_range(0, grid_rows - 1), random_order());
            end
            steps = 2 * grid_cols * grid_rows - 1 + $urandom_range(0, 2);
         end
         maze_open = 1'b0;
         if (steps > STEP_CAP) begin
            steps     = STEP_CAP;
            maze_open = 1'b1;
         end
         if ($urandom_range(99) < 15) begin
            steps     = $urandom_range(1, steps);
            maze_open = 1'b1;
         end

         for (int i = 0; i < steps; i++) begin
            if ($urandom_range(99) < 4) begin
               send_command(cmd_type'($urandom_range(0, 1)), $urandom_range(0, 31),
                            $urandom_range(0, 31), $urandom_range(0, 31));
            end else begin
               send_command(CMD_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                            random_order());
            end
         end
         phase++;
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
